### sv/sfa_pkg.sv
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared types and constants of the segment fit allocator.
// ----------------------------------------------------------------------------
package sfa_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int ADDR_BITS     = 16;
   localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
   localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);

   localparam logic [1:0] ACT_APPEND = 2'd0;
   localparam logic [1:0] ACT_ALLOC  = 2'd1;
   localparam logic [1:0] ACT_FREE   = 2'd2;

   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_OVERSIZE = 3'd1;
   localparam logic [2:0] ST_FRAG     = 3'd2;
   localparam logic [2:0] ST_NO_OWNER = 3'd3;
   localparam logic [2:0] ST_NO_ROOM  = 3'd4;

   // one table entry as held in memory
   typedef struct packed {
      logic [ADDR_BITS-1:0] start;
      logic [ADDR_BITS-1:0] size;
      logic                 used;
      logic [7:0]           owner;
      logic [1:0]           kind;
   } hole_type;

   // memory port request from the sequencer
   typedef struct packed {
      logic                rd_en;
      logic [IDX_BITS-1:0] rd_addr;
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_addr;
      hole_type            wr_data;
   } mem_req_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_APPEND,
      S_SCAN_RD,
      S_SCAN,
      S_SPLIT_RD,
      S_SPLIT,
      S_GRANT,
      S_FREE_RD,
      S_FREE,
      S_MERGE_RD,
      S_MERGE,
      S_SHDN_RD,
      S_SHDN,
      S_DONE
   } state_type;

endpackage

### sv/sfa_table.sv
// ----------------------------------------------------------------------------
// sfa_table
// Hole table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sfa_table
   import sfa_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output hole_type    rd_data
);

   hole_type mem [TABLE_ENTRIES];
   hole_type rd_data_ff;

   // write and read ports, registered output; a read of the entry being written returns the old entry
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/sfa_ctrl.sv
// ----------------------------------------------------------------------------
// sfa_ctrl
// Sequencer: scans, splits, frees and merges the hole table through the
// memory port, one entry access per cycle.
// ----------------------------------------------------------------------------
module sfa_ctrl
   import sfa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_action,
   input  logic [1:0]           req_fit_policy,
   input  logic [7:0]           req_owner_id,
   input  logic [1:0]           req_segment_kind,
   input  logic [15:0]          req_request_size,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_status,
   output logic [15:0]          rsp_base,
   output logic [15:0]          rsp_granted_size,
   output logic [15:0]          rsp_internal_waste,
   output mem_req_type          mem_req,
   input  hole_type             rd_data
);

   state_type state_ff, state_in;
   logic [1:0]  act_ff, act_in;
   logic [1:0]  pol_ff, pol_in;
   logic [7:0]  own_ff, own_in;
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] req_ff, req_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [ADDR_BITS-1:0] total_ff, total_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;   // scan pointer, read and write address
   logic [CNT_BITS-1:0] dst_ff, dst_in;   // merge write pointer
   logic                found_ff, found_in;
   logic                any_ff, any_in;
   logic [IDX_BITS-1:0] pick_ff, pick_in;
   logic [ADDR_BITS-1:0] psize_ff, psize_in;
   hole_type            hold_ff, hold_in;  // carried entry
   logic [16:0]         rnd_ff, rnd_in;    // rounded request
   logic                vld_ff, vld_in;
   logic [2:0]          st_ff, st_in;
   logic [15:0]         base_ff, base_in;
   logic [15:0]         gr_ff, gr_in;
   logic [15:0]         ws_ff, ws_in;

   logic [16:0]         newtot;
   logic                take;
   logic                fits;
   hole_type            cur;
   logic [ADDR_BITS:0]  sum;

   assign rsp_valid          = vld_ff;
   assign rsp_status         = st_ff;
   assign rsp_base           = base_ff;
   assign rsp_granted_size   = gr_ff;
   assign rsp_internal_waste = ws_ff;
   assign req_stall          = (state_ff != S_IDLE) || vld_ff;

   // hold state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         total_ff <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         total_ff <= total_in;
         vld_ff   <= vld_in;
      end
      act_ff <= act_in; pol_ff <= pol_in; own_ff <= own_in; kind_ff <= kind_in;
      req_ff <= req_in; idx_ff <= idx_in; dst_ff <= dst_in; found_ff <= found_in;
      any_ff <= any_in; pick_ff <= pick_in; psize_ff <= psize_in; hold_ff <= hold_in;
      rnd_ff <= rnd_in; st_ff <= st_in; base_ff <= base_in; gr_ff <= gr_in;
      ws_ff <= ws_in;
   end

   // next state, memory accesses
   always_comb begin
      state_in = state_ff; act_in = act_ff; pol_in = pol_ff; own_in = own_ff;
      kind_in = kind_ff; req_in = req_ff; cnt_in = cnt_ff; total_in = total_ff;
      idx_in = idx_ff; dst_in = dst_ff; found_in = found_ff; any_in = any_ff;
      pick_in = pick_ff; psize_in = psize_ff; hold_in = hold_ff; rnd_in = rnd_ff;
      vld_in = vld_ff; st_in = st_ff; base_in = base_ff; gr_in = gr_ff; ws_in = ws_ff;
      mem_req  = '0;
      cur      = rd_data;
      newtot   = {1'b0, total_ff} + {1'b0, req_ff};
      fits     = !cur.used && (cur.size >= req_ff);
      take     = 1'b0;
      sum      = {1'b0, hold_ff.size} + {1'b0, cur.size};
      if (vld_ff && !rsp_stall) begin
         vld_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               act_in = req_action; pol_in = req_fit_policy; own_in = req_owner_id;
               kind_in = req_segment_kind; req_in = req_request_size;
               st_in = ST_OK; base_in = '0; gr_in = '0; ws_in = '0;
               idx_in = '0; found_in = 1'b0; any_in = 1'b0; rnd_in = 17'd1;
               unique case (req_action)
                  ACT_APPEND: state_in = S_APPEND;
                  ACT_ALLOC:  state_in = S_SCAN_RD;
                  ACT_FREE:   state_in = S_FREE_RD;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_APPEND: begin
            if (cnt_ff >= CNT_BITS'(TABLE_ENTRIES) || newtot[16]) begin
               st_in = ST_NO_ROOM;
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = cnt_ff[IDX_BITS-1:0];
               mem_req.wr_data = '{start: total_ff, size: req_ff, used: 1'b0,
                                   owner: 8'd0, kind: 2'd0};
               cnt_in   = cnt_ff + 1'b1;
               total_in = newtot[15:0];
               base_in  = total_ff;
               gr_in    = req_ff;
            end
            state_in = S_DONE;
         end
         // issue read of entry idx, also step the rounding; end the scan past the last entry
         S_SCAN_RD: begin
            if (rnd_ff < {1'b0, req_ff}) begin
               rnd_in = {rnd_ff[15:0], 1'b0};
            end
            if (idx_ff >= cnt_ff) begin
               state_in = found_ff ? S_SPLIT_RD : S_DONE;
               if (!found_ff) begin
                  st_in = (total_ff < req_ff) ? ST_OVERSIZE : ST_FRAG;
               end
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_ff[IDX_BITS-1:0];
               state_in        = S_SCAN;
            end
         end
         S_SCAN: begin
            if (fits) begin
               if (pol_ff == FIT_BEST) begin
                  take = !found_ff || (cur.size < psize_ff);
               end else if (pol_ff == FIT_WORST) begin
                  take = !found_ff || (cur.size >= psize_ff);
               end else begin
                  take = 1'b1;
               end
            end
            if (take) begin
               found_in = 1'b1;
               pick_in  = idx_ff[IDX_BITS-1:0];
               psize_in = cur.size;
            end
            idx_in = idx_ff + 1'b1;
            if (take && pol_ff != FIT_BEST && pol_ff != FIT_WORST) begin
               idx_in = cnt_ff;
            end
            state_in = S_SCAN_RD;
         end
         S_SPLIT_RD: begin
            // finish rounding first
            if (rnd_ff < {1'b0, req_ff}) begin
               rnd_in = {rnd_ff[15:0], 1'b0};
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = pick_ff;
               state_in        = S_SPLIT;
            end
         end
         S_SPLIT: begin
            hold_in = cur;
            hold_in.used = 1'b1; hold_in.owner = own_ff; hold_in.kind = kind_ff;
            if ({1'b0, cur.size} > rnd_ff && cnt_ff < CNT_BITS'(TABLE_ENTRIES)) begin
               hold_in.size = rnd_ff[15:0];
               // shift entries above pick up by one, from the top
               idx_in   = cnt_ff;
               state_in = S_SHDN_RD;
               dst_in   = '1;
            end else begin
               state_in = S_GRANT;
            end
         end
         // shift up: move entry idx-1 to idx, down to pick+1
         S_SHDN_RD: begin
            if (idx_ff == CNT_BITS'(pick_ff) + 1'b1) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = idx_ff[IDX_BITS-1:0];
               mem_req.wr_data = '{start: hold_ff.start + rnd_ff[15:0],
                                   size: psize_ff - rnd_ff[15:0], used: 1'b0,
                                   owner: 8'd0, kind: 2'd0};
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_GRANT;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = IDX_BITS'(idx_ff - 1'b1);
               state_in        = S_SHDN;
            end
         end
         S_SHDN: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff[IDX_BITS-1:0];
            mem_req.wr_data = cur;
            idx_in   = idx_ff - 1'b1;
            state_in = S_SHDN_RD;
         end
         S_GRANT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pick_ff;
            mem_req.wr_data = hold_ff;
            base_in  = hold_ff.start;
            gr_in    = hold_ff.size;
            ws_in    = hold_ff.size - req_ff;
            state_in = S_DONE;
         end
         // release owner's entries
         S_FREE_RD: begin
            if (idx_ff >= cnt_ff) begin
               if (!any_ff) begin
                  st_in = ST_NO_OWNER;
               end
               idx_in = '0; dst_in = '0;
               state_in = (cnt_ff == '0) ? S_DONE : S_MERGE_RD;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_ff[IDX_BITS-1:0];
               state_in        = S_FREE;
            end
         end
         S_FREE: begin
            if (cur.used && cur.owner == own_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = idx_ff[IDX_BITS-1:0];
               mem_req.wr_data = cur;
               mem_req.wr_data.used  = 1'b0;
               mem_req.wr_data.owner = 8'd0;
               any_in = 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = S_FREE_RD;
         end
         // compact: hold carries the last kept entry, written at dst
         S_MERGE_RD: begin
            if (idx_ff >= cnt_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = dst_ff[IDX_BITS-1:0];
               mem_req.wr_data = hold_ff;
               cnt_in   = dst_ff + 1'b1;
               state_in = S_DONE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_ff[IDX_BITS-1:0];
               state_in        = S_MERGE;
            end
         end
         S_MERGE: begin
            if (idx_ff == '0) begin
               hold_in = cur;
            end else if (!hold_ff.used && !cur.used) begin
               hold_in.size = sum[ADDR_BITS-1:0];
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = dst_ff[IDX_BITS-1:0];
               mem_req.wr_data = hold_ff;
               dst_in  = dst_ff + 1'b1;
               hold_in = cur;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = S_MERGE_RD;
         end
         S_DONE: begin
            if (!vld_ff || !rsp_stall) begin
               vld_in   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

### sv/segment_fit_allocator_top.sv
// ----------------------------------------------------------------------------
// segment_fit_allocator_top
// Hole table allocator with first, best and worst fit.
// ----------------------------------------------------------------------------
// One word in, one word out. Append writes one new hole after the last entry.
// Allocate reads table entries for the fit scan (first fit stops at the first
// hole that fits), with the power of two rounding overlapped with the scan,
// and shifts entries up when a split inserts a hole. Free releases the owner's
// entries in one pass and merges adjacent free holes in a second. All passes run
// through the single read / single write port of the hole table memory (16
// entries). A new word is taken once the previous result is gone.
module segment_fit_allocator_top
   import sfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [1:0]  req_fit_policy,
   input  logic [7:0]  req_owner_id,
   input  logic [1:0]  req_segment_kind,
   input  logic [15:0] req_request_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_base,
   output logic [15:0] rsp_granted_size,
   output logic [15:0] rsp_internal_waste
);

   mem_req_type mem_req;
   hole_type    rd_data;

   sfa_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_action, .req_fit_policy,
      .req_owner_id, .req_segment_kind, .req_request_size, .rsp_valid,
      .rsp_stall, .rsp_status, .rsp_base, .rsp_granted_size,
      .rsp_internal_waste, .mem_req, .rd_data
   );

   sfa_table u_table (
      .clock, .mem_req, .rd_data
   );

endmodule
